FILE: rtl/bsad_pkg.sv
// shared types, codes and constants of the sensor advertisement decoder
`timescale 1ns / 1ps

package bsad_pkg;

  localparam int unsigned BSAD_STORE_DEPTH = 20;
  localparam int unsigned CountW = 8;
  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

  // length limits, counting the final byte
  localparam logic [CountW-1:0] MIN_LEN            = 8'd9;
  localparam logic [CountW-1:0] SCALE_LONG_MIN_LEN = 8'd13;

  // byte positions of the typed record
  localparam int unsigned OFF_THERMO = 11;
  localparam int unsigned OFF_PLANT  = 12;
  localparam int unsigned OFF_TO_LEN = 2;
  localparam int unsigned OFF_TO_DATA = 3;

  // magic bytes
  localparam logic [7:0] MAGIC_THERMO    = 8'hAA;
  localparam logic [7:0] MAGIC_PLANT     = 8'h98;
  localparam logic [7:0] PRODUCT_THERMO  = 8'h01;
  localparam logic [7:0] PRODUCT_PLANT   = 8'h00;
  localparam logic [7:0] MAGIC_SCALE_0   = 8'hE3;
  localparam logic [7:0] MAGIC_SCALE_1   = 8'h07;
  localparam logic [7:0] MAGIC_SCALE_2   = 8'h08;
  localparam int unsigned FLAG_BIT       = 5;

  // typed record codes
  localparam logic [7:0] TYPE_TEMP_HUM     = 8'h0D;
  localparam logic [7:0] TYPE_BATTERY      = 8'h0A;
  localparam logic [7:0] TYPE_HUMIDITY     = 8'h06;
  localparam logic [7:0] TYPE_TEMPERATURE  = 8'h04;
  localparam logic [7:0] TYPE_CONDUCTIVITY = 8'h09;
  localparam logic [7:0] TYPE_ILLUMINANCE  = 8'h07;
  localparam logic [7:0] TYPE_MOISTURE     = 8'h08;

  // scale unit codes
  localparam logic [7:0] UNIT_SHORT_METRIC_A = 8'h22;
  localparam logic [7:0] UNIT_SHORT_METRIC_B = 8'hA2;
  localparam logic [7:0] UNIT_SHORT_POUND_B  = 8'hB2;
  localparam logic [7:0] UNIT_LONG_METRIC    = 8'h02;
  localparam logic [7:0] UNIT_POUND          = 8'h03;

  // weight scaling: metric raw*500, pound floor(raw*56699/125) via reciprocal
  localparam int unsigned WeightW = 25;
  localparam int unsigned RawW = 16;
  localparam logic [8:0] W_METRIC_MULT = 9'd500;
  localparam int unsigned W_LB_SHIFT = 23;
  localparam logic [31:0] W_LB_MULT =
    32'(((64'd56699 << W_LB_SHIFT) + 64'd124) / 64'd125);

  typedef enum logic [1:0] {
    UUID_FE95 = 2'd0,
    UUID_181D = 2'd1,
    UUID_181B = 2'd2,
    UUID_NONE = 2'd3
  } uuid_kind_e;

  typedef enum logic [1:0] {
    DEV_THERMO = 2'd0,
    DEV_PLANT  = 2'd1,
    DEV_SCALE  = 2'd2
  } device_kind_e;

  typedef enum logic [2:0] {
    RD_TEMP_HUM     = 3'd0,
    RD_BATTERY      = 3'd1,
    RD_HUMIDITY     = 3'd2,
    RD_TEMPERATURE  = 3'd3,
    RD_CONDUCTIVITY = 3'd4,
    RD_ILLUMINANCE  = 3'd5,
    RD_MOISTURE     = 3'd6,
    RD_WEIGHT       = 3'd7
  } reading_kind_e;

  typedef enum logic [1:0] {
    WU_NONE   = 2'd0,
    WU_METRIC = 2'd1,
    WU_POUND  = 2'd2
  } weight_unit_e;

  typedef struct packed {
    logic          ok;
    device_kind_e  device_kind;
    reading_kind_e reading_kind;
    logic [15:0]   temperature;
    logic [15:0]   humidity;
    logic [7:0]    battery;
    logic [15:0]   conductivity;
    logic [23:0]   illuminance;
    logic [7:0]    moisture;
    weight_unit_e  weight_unit;
    logic [RawW-1:0] weight_raw;
  } decode_t;

endpackage

FILE: rtl/bsad_frame.sv
// byte store, byte count and length overflow flag of the current packet
`timescale 1ns / 1ps

module bsad_frame
  import bsad_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = BSAD_STORE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_last_i,
  output logic [7:0]        view_o [STORE_DEPTH],
  output logic [CountW-1:0] pkt_len_o,
  output logic              len_bad_o
);

  localparam int unsigned IdxW = $clog2(STORE_DEPTH);

  logic [7:0]        store_q [STORE_DEPTH];
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept_i) begin
      if (byte_last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (count_q == COUNT_MAX) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && count_q < CountW'(STORE_DEPTH)) begin
      store_q[count_q[IdxW-1:0]] <= data_byte_i;
    end
  end

  // packet as seen with the incoming byte; bytes past the end read as zero
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_view
    assign view_o[i] = (count_q == CountW'(i)) ? data_byte_i :
                       (count_q >  CountW'(i)) ? store_q[i]  : 8'h00;
  end

  assign pkt_len_o = count_q + 8'd1;
  assign len_bad_o = ovf_q || (count_q == COUNT_MAX);

endmodule

FILE: rtl/bsad_parse.sv
// packet match, length checks and field decode into the first pipeline register
`timescale 1ns / 1ps

module bsad_parse
  import bsad_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = BSAD_STORE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              adv_i,
  input  logic [7:0]        view_i [STORE_DEPTH],
  input  logic [CountW-1:0] pkt_len_i,
  input  logic              len_bad_i,
  input  logic [1:0]        uuid_kind_i,
  output logic              free_o,
  output logic              s1_valid_o,
  output decode_t           s1_o
);

  logic          s1_valid_q, s1_valid_d;
  decode_t       s1_q, dec;

  logic          flag20, thermo, plant, scale_fwd, scale_bfs, short_form;
  logic [7:0]    tlv_type, tlv_len, b0, b1, b2, b3, unit;
  logic [8:0]    tlv_end;
  logic          known;
  logic [7:0]    exp_len;
  reading_kind_e rk;
  weight_unit_e  wu;
  logic [RawW-1:0] raw;

  assign flag20    = view_i[1][FLAG_BIT];
  assign thermo    = flag20 && view_i[2] == MAGIC_THERMO && view_i[3] == PRODUCT_THERMO;
  assign plant     = flag20 && view_i[2] == MAGIC_PLANT && view_i[3] == PRODUCT_PLANT;
  assign scale_fwd = view_i[3] == MAGIC_SCALE_0 && view_i[4] == MAGIC_SCALE_1 &&
                     view_i[5] == MAGIC_SCALE_2;
  assign scale_bfs = view_i[2] == MAGIC_SCALE_0 && view_i[3] == MAGIC_SCALE_1 &&
                     view_i[4] == MAGIC_SCALE_2;

  // record layout differs by one byte between the two sensor kinds
  assign tlv_type = thermo ? view_i[OFF_THERMO] : view_i[OFF_PLANT];
  assign tlv_len  = thermo ? view_i[OFF_THERMO + OFF_TO_LEN] : view_i[OFF_PLANT + OFF_TO_LEN];
  assign b0 = thermo ? view_i[OFF_THERMO + OFF_TO_DATA]     : view_i[OFF_PLANT + OFF_TO_DATA];
  assign b1 = thermo ? view_i[OFF_THERMO + OFF_TO_DATA + 1] : view_i[OFF_PLANT + OFF_TO_DATA + 1];
  assign b2 = thermo ? view_i[OFF_THERMO + OFF_TO_DATA + 2] : view_i[OFF_PLANT + OFF_TO_DATA + 2];
  assign b3 = thermo ? view_i[OFF_THERMO + OFF_TO_DATA + 3] : view_i[OFF_PLANT + OFF_TO_DATA + 3];
  assign tlv_end = {1'b0, tlv_len} +
                   (thermo ? 9'(OFF_THERMO + OFF_TO_DATA) : 9'(OFF_PLANT + OFF_TO_DATA));

  always_comb begin
    known   = 1'b1;
    exp_len = 8'd1;
    rk      = RD_BATTERY;
    case (tlv_type)
      TYPE_TEMP_HUM: begin
        exp_len = 8'd4;
        rk      = RD_TEMP_HUM;
      end
      TYPE_BATTERY: begin
        exp_len = 8'd1;
        rk      = RD_BATTERY;
      end
      TYPE_HUMIDITY: begin
        exp_len = 8'd2;
        rk      = RD_HUMIDITY;
      end
      TYPE_TEMPERATURE: begin
        exp_len = 8'd2;
        rk      = RD_TEMPERATURE;
      end
      TYPE_CONDUCTIVITY: begin
        exp_len = 8'd2;
        rk      = RD_CONDUCTIVITY;
      end
      TYPE_ILLUMINANCE: begin
        exp_len = 8'd3;
        rk      = RD_ILLUMINANCE;
      end
      TYPE_MOISTURE: begin
        exp_len = 8'd1;
        rk      = RD_MOISTURE;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // scale short form sits at the front, long form carries the weight at 11..12
  assign short_form = (uuid_kind_i == UUID_181B) && !scale_bfs;
  assign unit       = view_i[0];
  assign raw        = short_form ? {view_i[2], view_i[1]} : {view_i[12], view_i[11]};

  always_comb begin
    wu = WU_NONE;
    if (short_form) begin
      if (unit inside {UNIT_SHORT_METRIC_A, UNIT_SHORT_METRIC_B}) begin
        wu = WU_METRIC;
      end else if (unit inside {UNIT_POUND, UNIT_SHORT_POUND_B}) begin
        wu = WU_POUND;
      end
    end else begin
      if (unit == UNIT_LONG_METRIC) begin
        wu = WU_METRIC;
      end else if (unit == UNIT_POUND) begin
        wu = WU_POUND;
      end
    end
  end

  always_comb begin
    dec = '0;
    if (!len_bad_i && uuid_kind_i != UUID_NONE && pkt_len_i >= MIN_LEN) begin
      if (thermo || plant) begin
        if (tlv_end == {1'b0, pkt_len_i} && known && tlv_len == exp_len) begin
          dec.ok           = 1'b1;
          dec.device_kind  = thermo ? DEV_THERMO : DEV_PLANT;
          dec.reading_kind = rk;
          case (rk)
            RD_TEMP_HUM: begin
              dec.temperature = {b1, b0};
              dec.humidity    = {b3, b2};
            end
            RD_BATTERY:      dec.battery      = b0;
            RD_HUMIDITY:     dec.humidity     = {b1, b0};
            RD_TEMPERATURE:  dec.temperature  = {b1, b0};
            RD_CONDUCTIVITY: dec.conductivity = {b1, b0};
            RD_ILLUMINANCE:  dec.illuminance  = {b2, b1, b0};
            RD_MOISTURE:     dec.moisture     = b0;
            default: ;
          endcase
        end
      end else if (scale_fwd || scale_bfs) begin
        if ((short_form || pkt_len_i >= SCALE_LONG_MIN_LEN) && wu != WU_NONE) begin
          dec.ok           = 1'b1;
          dec.device_kind  = DEV_SCALE;
          dec.reading_kind = RD_WEIGHT;
          dec.weight_unit  = wu;
          dec.weight_raw   = raw;
        end
      end
    end
  end

  assign free_o = !s1_valid_q || adv_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (free_o) begin
      s1_valid_d = take_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && free_o) begin
      s1_q <= dec;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

FILE: rtl/bsad_emit.sv
// weight scaling and the result register
`timescale 1ns / 1ps

module bsad_emit
  import bsad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  decode_t            s1_i,
  input  logic               out_stall_i,
  output logic               adv_o,
  output logic               out_valid_o,
  output logic               packet_ok_o,
  output logic [1:0]         device_kind_o,
  output logic [2:0]         reading_kind_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic signed [15:0] humidity_tenths_o,
  output logic [7:0]         battery_percent_o,
  output logic [15:0]        conductivity_us_o,
  output logic [23:0]        illuminance_lux_o,
  output logic [7:0]         moisture_percent_o,
  output logic [WeightW-1:0] weight_centigrams_o
);

  logic               out_valid_q, out_valid_d;
  decode_t            res_q;
  logic [WeightW-1:0] weight_q, weight_d;
  logic [WeightW-1:0] metric_w;
  logic [47:0]        lb_prod;

  assign metric_w = WeightW'(s1_i.weight_raw) * WeightW'(W_METRIC_MULT);
  // reciprocal of 125 folded into the pound factor, exact for 16-bit raw values
  assign lb_prod  = 48'(s1_i.weight_raw) * 48'(W_LB_MULT);

  always_comb begin
    case (s1_i.weight_unit)
      WU_METRIC: weight_d = metric_w;
      WU_POUND:  weight_d = WeightW'(lb_prod >> W_LB_SHIFT);
      default:   weight_d = '0;
    endcase
  end

  assign adv_o = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_o) begin
      out_valid_d = s1_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      res_q    <= s1_i;
      weight_q <= weight_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign packet_ok_o          = res_q.ok;
  assign device_kind_o        = res_q.device_kind;
  assign reading_kind_o       = res_q.reading_kind;
  assign temperature_tenths_o = res_q.temperature;
  assign humidity_tenths_o    = res_q.humidity;
  assign battery_percent_o    = res_q.battery;
  assign conductivity_us_o    = res_q.conductivity;
  assign illuminance_lux_o    = res_q.illuminance;
  assign moisture_percent_o   = res_q.moisture;
  assign weight_centigrams_o  = weight_q;

endmodule

FILE: rtl/ble_sensor_advert_decoder_core.sv
// top level of the sensor advertisement service-data decoder
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | data_byte_i, byte_last_i, uuid_kind_i
//   out     | output    | out_valid_o/out_stall_i | packet_ok_o .. weight_centigrams_o
//
// one byte is taken every cycle while in_stall_o is low; a packet's result is registered after its last byte
// the path is decode register, then weight multiply into the result register
// reset clears the byte count, the overflow flag and both valid flags; the store is not cleared
// a stalled result holds; the decode register fills behind it, then in_stall_o rises
`timescale 1ns / 1ps

module ble_sensor_advert_decoder_core
  import bsad_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = BSAD_STORE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_last_i,
  input  logic [1:0]         uuid_kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               packet_ok_o,
  output logic [1:0]         device_kind_o,
  output logic [2:0]         reading_kind_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic signed [15:0] humidity_tenths_o,
  output logic [7:0]         battery_percent_o,
  output logic [15:0]        conductivity_us_o,
  output logic [23:0]        illuminance_lux_o,
  output logic [7:0]         moisture_percent_o,
  output logic [WeightW-1:0] weight_centigrams_o
);

  logic              accept, free, adv, s1_valid, len_bad;
  logic [7:0]        view [STORE_DEPTH];
  logic [CountW-1:0] pkt_len;
  decode_t           s1;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  bsad_frame #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .byte_last_i (byte_last_i),
    .view_o      (view),
    .pkt_len_o   (pkt_len),
    .len_bad_o   (len_bad)
  );

  bsad_parse #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (accept && byte_last_i),
    .adv_i       (adv),
    .view_i      (view),
    .pkt_len_i   (pkt_len),
    .len_bad_i   (len_bad),
    .uuid_kind_i (uuid_kind_i),
    .free_o      (free),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1)
  );

  bsad_emit u_emit (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .s1_valid_i           (s1_valid),
    .s1_i                 (s1),
    .out_stall_i          (out_stall_i),
    .adv_o                (adv),
    .out_valid_o          (out_valid_o),
    .packet_ok_o          (packet_ok_o),
    .device_kind_o        (device_kind_o),
    .reading_kind_o       (reading_kind_o),
    .temperature_tenths_o (temperature_tenths_o),
    .humidity_tenths_o    (humidity_tenths_o),
    .battery_percent_o    (battery_percent_o),
    .conductivity_us_o    (conductivity_us_o),
    .illuminance_lux_o    (illuminance_lux_o),
    .moisture_percent_o   (moisture_percent_o),
    .weight_centigrams_o  (weight_centigrams_o)
  );

endmodule

FILE: rtl/bsad_checker.sv
// port-level checks of the decoder, bound to the top level
`timescale 1ns / 1ps

module bsad_checker
  import bsad_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [7:0]         data_byte_i,
  input logic               byte_last_i,
  input logic [1:0]         uuid_kind_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               packet_ok_o,
  input logic [1:0]         device_kind_o,
  input logic [2:0]         reading_kind_o,
  input logic signed [15:0] temperature_tenths_o,
  input logic signed [15:0] humidity_tenths_o,
  input logic [7:0]         battery_percent_o,
  input logic [15:0]        conductivity_us_o,
  input logic [23:0]        illuminance_lux_o,
  input logic [7:0]         moisture_percent_o,
  input logic [WeightW-1:0] weight_centigrams_o
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a rejected packet carries no reading
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !packet_ok_o |->
      device_kind_o == 2'd0 && reading_kind_o == 3'd0 &&
      temperature_tenths_o == 16'sd0 && humidity_tenths_o == 16'sd0 &&
      battery_percent_o == 8'd0 && conductivity_us_o == 16'd0 &&
      illuminance_lux_o == 24'd0 && moisture_percent_o == 8'd0 &&
      weight_centigrams_o == '0)
    else $error("rejected packet with nonzero fields");

  a_weight_from_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_ok_o && reading_kind_o == RD_WEIGHT |->
      device_kind_o == DEV_SCALE)
    else $error("weight reading from a non-scale device");

  a_weight_only_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_ok_o && reading_kind_o != RD_WEIGHT |->
      weight_centigrams_o == '0 && device_kind_o != DEV_SCALE)
    else $error("weight field set on a sensor reading");

endmodule

bind ble_sensor_advert_decoder_core bsad_checker u_bsad_checker (.*);

FILE: tb/bsad_report_checker.sv
// scoreboard for the advertisement decoder: tracks packets, predicts and checks each report
`timescale 1ns / 1ps

module bsad_report_checker
  import bsad_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = BSAD_STORE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_last_i,
  input  logic [1:0]         uuid_kind_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               packet_ok_i,
  input  logic [1:0]         device_kind_i,
  input  logic [2:0]         reading_kind_i,
  input  logic [15:0]        temperature_tenths_i,
  input  logic [15:0]        humidity_tenths_i,
  input  logic [7:0]         battery_percent_i,
  input  logic [15:0]        conductivity_us_i,
  input  logic [23:0]        illuminance_lux_i,
  input  logic [7:0]         moisture_percent_i,
  input  logic [WeightW-1:0] weight_centigrams_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        reports_seen_o,
  output int unsigned        decoded_seen_o
);

  localparam longint unsigned LB_CG_NUM = 64'd453592;
  localparam longint unsigned LB_CG_DEN = 64'd1000;
  localparam int unsigned UNIT_AT      = 0;
  localparam int unsigned SHORT_RAW_AT = 1;
  localparam int unsigned LONG_RAW_AT  = 11;

  typedef struct packed {
    logic               ok;
    device_kind_e       device;
    reading_kind_e      reading;
    logic [15:0]        temperature;
    logic [15:0]        humidity;
    logic [7:0]         battery;
    logic [15:0]        conductivity;
    logic [23:0]        illuminance;
    logic [7:0]         moisture;
    logic [WeightW-1:0] weight;
  } report_t;

  logic [7:0]  packet_bytes [STORE_DEPTH];
  logic [7:0]  byte_total = '0;
  logic        too_long = 1'b0;
  report_t     expected_reports [$];
  int unsigned fails = 0;
  int unsigned reports_seen = 0;
  int unsigned decoded_seen = 0;

  // bytes past the packet end or past the store read as zero
  function automatic logic [7:0] stored_byte(input int unsigned idx);
    if (idx >= byte_total || idx >= STORE_DEPTH) return 8'h00;
    return packet_bytes[idx];
  endfunction

  function automatic logic [15:0] stored_le16(input int unsigned idx);
    return {stored_byte(idx + 1), stored_byte(idx)};
  endfunction

  function automatic bit weigh(input logic [7:0] unit, input logic [15:0] raw,
                               input bit long_form, inout report_t r);
    bit metric, pound;
    longint unsigned cg;
    if (long_form) begin
      metric = (unit == UNIT_LONG_METRIC);
      pound  = (unit == UNIT_POUND);
    end else begin
      metric = (unit == UNIT_SHORT_METRIC_A) || (unit == UNIT_SHORT_METRIC_B);
      pound  = (unit == UNIT_POUND) || (unit == UNIT_SHORT_POUND_B);
    end
    if (metric) begin
      cg = 64'(raw) * 64'(W_METRIC_MULT);
    end else if (pound) begin
      cg = (64'(raw) * LB_CG_NUM) / LB_CG_DEN;
    end else begin
      return 1'b0;
    end
    r.reading = RD_WEIGHT;
    r.weight  = WeightW'(cg);
    return 1'b1;
  endfunction

  function automatic bit typed_record(input logic [7:0] rtype, input int unsigned len,
                                      input int unsigned base, inout report_t r);
    bit ok;
    ok = 1'b0;
    case (rtype)
      TYPE_TEMP_HUM: if (len == 4) begin
        r.reading     = RD_TEMP_HUM;
        r.temperature = stored_le16(base);
        r.humidity    = stored_le16(base + 2);
        ok = 1'b1;
      end
      TYPE_BATTERY: if (len == 1) begin
        r.reading = RD_BATTERY;
        r.battery = stored_byte(base);
        ok = 1'b1;
      end
      TYPE_HUMIDITY: if (len == 2) begin
        r.reading  = RD_HUMIDITY;
        r.humidity = stored_le16(base);
        ok = 1'b1;
      end
      TYPE_TEMPERATURE: if (len == 2) begin
        r.reading     = RD_TEMPERATURE;
        r.temperature = stored_le16(base);
        ok = 1'b1;
      end
      TYPE_CONDUCTIVITY: if (len == 2) begin
        r.reading      = RD_CONDUCTIVITY;
        r.conductivity = stored_le16(base);
        ok = 1'b1;
      end
      TYPE_ILLUMINANCE: if (len == 3) begin
        r.reading     = RD_ILLUMINANCE;
        r.illuminance = {stored_byte(base + 2), stored_le16(base)};
        ok = 1'b1;
      end
      TYPE_MOISTURE: if (len == 1) begin
        r.reading  = RD_MOISTURE;
        r.moisture = stored_byte(base);
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // report for the packet just closed; uses the count that includes the last byte
  function automatic report_t predict_report(input logic [1:0] uuid);
    report_t r;
    int unsigned n, off, len;
    logic [7:0] rtype, flags;
    bit flagged, thermo, plant, scale_hi, scale_lo, good;
    r = '0;
    good = 1'b0;
    n = byte_total;
    flags = stored_byte(1);
    flagged = flags[FLAG_BIT];
    if (!too_long && uuid != UUID_NONE && n >= MIN_LEN) begin
      thermo = flagged && stored_byte(2) == MAGIC_THERMO && stored_byte(3) == PRODUCT_THERMO;
      plant  = flagged && stored_byte(2) == MAGIC_PLANT && stored_byte(3) == PRODUCT_PLANT;
      scale_hi = stored_byte(3) == MAGIC_SCALE_0 && stored_byte(4) == MAGIC_SCALE_1 &&
                 stored_byte(5) == MAGIC_SCALE_2;
      scale_lo = stored_byte(2) == MAGIC_SCALE_0 && stored_byte(3) == MAGIC_SCALE_1 &&
                 stored_byte(4) == MAGIC_SCALE_2;
      if (thermo || plant) begin
        off   = thermo ? OFF_THERMO : OFF_PLANT;
        rtype = stored_byte(off);
        len   = stored_byte(off + OFF_TO_LEN);
        if (len + off + OFF_TO_DATA == n) begin
          r.device = thermo ? DEV_THERMO : DEV_PLANT;
          good = typed_record(rtype, len, off + OFF_TO_DATA, r);
        end
      end else if (scale_hi || scale_lo) begin
        r.device = DEV_SCALE;
        // short form only for the body-composition uuid without the low magic
        if (uuid == UUID_181B && !scale_lo) begin
          good = weigh(stored_byte(UNIT_AT), stored_le16(SHORT_RAW_AT), 1'b0, r);
        end else if (n >= SCALE_LONG_MIN_LEN) begin
          good = weigh(stored_byte(UNIT_AT), stored_le16(LONG_RAW_AT), 1'b1, r);
        end
      end
    end
    if (good) r.ok = 1'b1;
    else r = '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    report_t want;
    if (!rst_ni) begin
      byte_total = '0;
      too_long   = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (byte_total == COUNT_MAX) begin
          too_long = 1'b1;
        end else begin
          if (byte_total < STORE_DEPTH) packet_bytes[byte_total] = data_byte_i;
          byte_total++;
        end
        if (byte_last_i) begin
          expected_reports.push_back(predict_report(uuid_kind_i));
          byte_total = '0;
          too_long   = 1'b0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("report transaction with no packet outstanding");
          fails++;
        end else begin
          want = expected_reports.pop_front();
          if (want.ok) decoded_seen++;
          check_field("packet_ok", want.ok, packet_ok_i);
          check_field("device_kind", want.device, device_kind_i);
          check_field("reading_kind", want.reading, reading_kind_i);
          check_field("temperature_tenths", want.temperature, temperature_tenths_i);
          check_field("humidity_tenths", want.humidity, humidity_tenths_i);
          check_field("battery_percent", want.battery, battery_percent_i);
          check_field("conductivity_us", want.conductivity, conductivity_us_i);
          check_field("illuminance_lux", want.illuminance, illuminance_lux_i);
          check_field("moisture_percent", want.moisture, moisture_percent_i);
          check_field("weight_centigrams", want.weight, weight_centigrams_i);
        end
      end
    end
    fail_count_o   <= fails;
    pending_o      <= expected_reports.size();
    reports_seen_o <= reports_seen;
    decoded_seen_o <= decoded_seen;
  end

endmodule

FILE: tb/tb_ble_sensor_advert_decoder_core.sv
// testbench top: packet stimulus, result sink, watchdog and verdict for the decoder
`timescale 1ns / 1ps

module tb_ble_sensor_advert_decoder_core;
  import bsad_pkg::*;

  localparam int unsigned N_BYTES        = 400;
  localparam int unsigned MIN_PACKETS    = 30;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [7:0] TYPE_UNUSED = 8'h01;

  localparam logic [7:0] REC_TYPES [7] = '{TYPE_TEMP_HUM, TYPE_BATTERY, TYPE_HUMIDITY,
    TYPE_TEMPERATURE, TYPE_CONDUCTIVITY, TYPE_ILLUMINANCE, TYPE_MOISTURE};
  localparam int unsigned REC_LENS [7] = '{4, 1, 2, 2, 2, 3, 1};
  localparam logic [7:0] SHORT_UNITS [4] = '{UNIT_SHORT_METRIC_A, UNIT_SHORT_METRIC_B,
    UNIT_POUND, UNIT_SHORT_POUND_B};
  localparam logic [7:0] LONG_UNITS [2] = '{UNIT_LONG_METRIC, UNIT_POUND};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i = '0;
  logic               byte_last_i = 1'b0;
  logic [1:0]         uuid_kind_i = UUID_FE95;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               packet_ok_o;
  logic [1:0]         device_kind_o;
  logic [2:0]         reading_kind_o;
  logic signed [15:0] temperature_tenths_o;
  logic signed [15:0] humidity_tenths_o;
  logic [7:0]         battery_percent_o;
  logic [15:0]        conductivity_us_o;
  logic [23:0]        illuminance_lux_o;
  logic [7:0]         moisture_percent_o;
  logic [WeightW-1:0] weight_centigrams_o;

  int unsigned fail_count, pending, reports_seen, decoded_seen;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned idle_cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic [7:0]  pkt [$];

  always #1 clk_i = ~clk_i;

  ble_sensor_advert_decoder_core #(
    .STORE_DEPTH(BSAD_STORE_DEPTH)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .byte_last_i         (byte_last_i),
    .uuid_kind_i         (uuid_kind_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .packet_ok_o         (packet_ok_o),
    .device_kind_o       (device_kind_o),
    .reading_kind_o      (reading_kind_o),
    .temperature_tenths_o(temperature_tenths_o),
    .humidity_tenths_o   (humidity_tenths_o),
    .battery_percent_o   (battery_percent_o),
    .conductivity_us_o   (conductivity_us_o),
    .illuminance_lux_o   (illuminance_lux_o),
    .moisture_percent_o  (moisture_percent_o),
    .weight_centigrams_o (weight_centigrams_o)
  );

  bsad_report_checker #(
    .STORE_DEPTH(BSAD_STORE_DEPTH)
  ) report_chk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .byte_last_i         (byte_last_i),
    .uuid_kind_i         (uuid_kind_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .packet_ok_i         (packet_ok_o),
    .device_kind_i       (device_kind_o),
    .reading_kind_i      (reading_kind_o),
    .temperature_tenths_i($unsigned(temperature_tenths_o)),
    .humidity_tenths_i   ($unsigned(humidity_tenths_o)),
    .battery_percent_i   (battery_percent_o),
    .conductivity_us_i   (conductivity_us_o),
    .illuminance_lux_i   (illuminance_lux_o),
    .moisture_percent_i  (moisture_percent_o),
    .weight_centigrams_i (weight_centigrams_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .reports_seen_o      (reports_seen),
    .decoded_seen_o      (decoded_seen)
  );

  // idle draw per transaction, with calm stretches of back-to-back traffic
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic fill_noise(input int unsigned n);
    pkt.delete();
    repeat (n) pkt.push_back(8'($urandom));
  endtask

  task automatic put(input int unsigned idx, input logic [7:0] v);
    if (idx < pkt.size()) pkt[idx] = v;
  endtask

  task automatic trim(input int unsigned n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  // flagged frame with magic, typed record header and little-endian record body
  task automatic build_typed(input bit plant, input logic [7:0] rtype,
                             input int unsigned dlen, input logic [31:0] val);
    int unsigned off;
    off = plant ? OFF_PLANT : OFF_THERMO;
    fill_noise(dlen + off + OFF_TO_DATA);
    pkt[1] = pkt[1] | (8'h01 << FLAG_BIT);
    pkt[2] = plant ? MAGIC_PLANT : MAGIC_THERMO;
    pkt[3] = plant ? PRODUCT_PLANT : PRODUCT_THERMO;
    pkt[off] = rtype;
    pkt[off + OFF_TO_LEN] = 8'(dlen);
    for (int i = 0; i < dlen && i < 4; i++) pkt[off + OFF_TO_DATA + i] = val[8*i +: 8];
  endtask

  // low_magic puts the magic at bytes 2..4, otherwise at 3..5 with the short-form raw at 1..2
  task automatic build_scale(input bit low_magic, input logic [7:0] unit,
                             input logic [15:0] raw, input int unsigned n);
    fill_noise(n);
    put(0, unit);
    if (low_magic) begin
      put(2, MAGIC_SCALE_0);
      put(3, MAGIC_SCALE_1);
      put(4, MAGIC_SCALE_2);
    end else begin
      put(1, raw[7:0]);
      put(2, raw[15:8]);
      put(3, MAGIC_SCALE_0);
      put(4, MAGIC_SCALE_1);
      put(5, MAGIC_SCALE_2);
    end
    put(11, raw[7:0]);
    put(12, raw[15:8]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [1:0] uuid);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    byte_last_i <= last;
    uuid_kind_i <= uuid;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // only the uuid on the last byte matters, the others are scrambled
  task automatic send_packet(input logic [1:0] uuid);
    foreach (pkt[i]) begin
      if (i == pkt.size() - 1) send_byte(pkt[i], 1'b1, uuid);
      else send_byte(pkt[i], 1'b0, 2'($urandom_range(0, 3)));
    end
    packets_sent++;
  endtask

  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = draw_gap(out_calm);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned kind, pick, n;
    bit alt;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every record type, signed and unsigned extremes
    build_typed(1'b0, TYPE_TEMP_HUM, 4, 32'h7FFF_8000);     send_packet(UUID_FE95);
    build_typed(1'b0, TYPE_BATTERY, 1, 32'h0000_00FF);      send_packet(UUID_181D);
    build_typed(1'b0, TYPE_HUMIDITY, 2, 32'h0000_FC18);     send_packet(UUID_181B);
    build_typed(1'b1, TYPE_TEMPERATURE, 2, 32'h0000_8000);  send_packet(UUID_FE95);
    build_typed(1'b1, TYPE_CONDUCTIVITY, 2, 32'h0000_FFFF); send_packet(UUID_FE95);
    build_typed(1'b1, TYPE_ILLUMINANCE, 3, 32'h00FF_FFFF);  send_packet(UUID_181D);
    build_typed(1'b1, TYPE_MOISTURE, 1, 32'h0000_0000);     send_packet(UUID_FE95);
    // rejects: unknown type, wrong record length, length byte disagrees, uuid none
    build_typed(1'b0, TYPE_UNUSED, 1, 32'h0);               send_packet(UUID_FE95);
    build_typed(1'b0, TYPE_BATTERY, 2, 32'h55);             send_packet(UUID_FE95);
    build_typed(1'b1, TYPE_MOISTURE, 1, 32'h42);
    pkt.push_back(8'h00);                                   send_packet(UUID_FE95);
    build_typed(1'b0, TYPE_TEMP_HUM, 4, 32'h0123_4567);     send_packet(UUID_NONE);
    // too short
    build_typed(1'b0, TYPE_BATTERY, 1, 32'h10);
    trim(8);                                                send_packet(UUID_FE95);
    fill_noise(1);                                          send_packet(UUID_181B);
    // scale short form, all units, raw extremes
    build_scale(1'b0, UNIT_SHORT_METRIC_A, 16'hFFFF, 9);    send_packet(UUID_181B);
    build_scale(1'b0, UNIT_SHORT_METRIC_B, 16'h0000, 10);   send_packet(UUID_181B);
    build_scale(1'b0, UNIT_POUND, 16'hFFFF, 9);             send_packet(UUID_181B);
    build_scale(1'b0, UNIT_SHORT_POUND_B, 16'h0003, 13);    send_packet(UUID_181B);
    build_scale(1'b0, UNIT_LONG_METRIC, 16'h1234, 13);      send_packet(UUID_181B);
    // scale long form, short long-form packet, unknown unit
    build_scale(1'b1, UNIT_LONG_METRIC, 16'hFFFF, 13);      send_packet(UUID_FE95);
    build_scale(1'b0, UNIT_POUND, 16'hFFFF, 14);            send_packet(UUID_181D);
    build_scale(1'b1, UNIT_POUND, 16'h0101, 12);            send_packet(UUID_181B);
    build_scale(1'b1, UNIT_SHORT_METRIC_A, 16'h0101, 16);   send_packet(UUID_181B);
    // over the length limit
    build_typed(1'b0, TYPE_BATTERY, 1, 32'h20);
    repeat (256 - pkt.size()) pkt.push_back(8'($urandom)); send_packet(UUID_FE95);

    // mostly well-formed frames with random content, the rest damaged or noise
    while (bytes_sent < N_BYTES || packets_sent < MIN_PACKETS) begin
      kind = $urandom_range(0, 15);
      pick = $urandom_range(0, 6);
      alt  = 1'($urandom_range(0, 1));
      case (kind)
        0, 1, 2, 3, 4: begin
          build_typed(alt, REC_TYPES[pick], REC_LENS[pick], $urandom);
          send_packet(2'($urandom_range(0, 2)));
        end
        5: begin
          build_typed(alt, 8'($urandom_range(0, 15)), $urandom_range(0, 5), $urandom);
          send_packet(2'($urandom_range(0, 2)));
        end
        6, 7: begin
          build_scale(1'b0, SHORT_UNITS[$urandom_range(0, 3)], 16'($urandom),
                      $urandom_range(9, 16));
          send_packet(UUID_181B);
        end
        8, 9: begin
          build_scale(alt, LONG_UNITS[$urandom_range(0, 1)], 16'($urandom),
                      $urandom_range(13, 20));
          send_packet(alt ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 1)));
        end
        10: begin
          build_scale(alt, 8'($urandom), 16'($urandom), $urandom_range(6, 16));
          send_packet(2'($urandom_range(0, 3)));
        end
        11: begin
          build_typed(alt, REC_TYPES[pick], REC_LENS[pick], $urandom);
          pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
          send_packet(2'($urandom_range(0, 2)));
        end
        12: begin
          build_typed(alt, REC_TYPES[pick], REC_LENS[pick], $urandom);
          if ($urandom_range(0, 1) != 0) trim($urandom_range(1, pkt.size() - 1));
          else pkt.push_back(8'($urandom));
          send_packet(2'($urandom_range(0, 2)));
        end
        13: begin
          build_typed(alt, REC_TYPES[pick], REC_LENS[pick], $urandom);
          send_packet(UUID_NONE);
        end
        14: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 20);
          fill_noise(n);
          send_packet(2'($urandom_range(0, 3)));
        end
        default: begin
          build_scale(1'b1, LONG_UNITS[$urandom_range(0, 1)], 16'($urandom),
                      $urandom_range(9, 12));
          send_packet(2'($urandom_range(0, 2)));
        end
      endcase
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d packets in %0d bytes; %0d reports checked, %0d decoded",
             packets_sent, bytes_sent, reports_seen, decoded_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
